@@ rtl/apg_pkg.sv @@
`timescale 1ns / 1ps
// Shared types and constants for the arc point generator.
// Used by the phase divider, the CORDIC rotator and the top level; no dependencies.
package apg_pkg;

    localparam int unsigned FULL_ARC  = 92160;
    localparam int unsigned MIN_SEG   = 3;
    localparam int unsigned Q_BITS    = 33;
    localparam int unsigned PROD_W    = 27;
    localparam int unsigned PHASE_W   = 32;
    localparam int unsigned OUT_W     = 22;
    localparam logic [31:0] GAIN_Q32  = 32'd2608131496;

    localparam logic [1:0] CFG_RADIUS = 2'd0;
    localparam logic [1:0] CFG_SEG    = 2'd1;
    localparam logic [1:0] CFG_ARC    = 2'd2;

    // Flags that ride alongside each item through the pipeline.
    typedef struct packed {
        logic point_valid;
        logic last_point;
        logic curve_closed;
    } t_side;

    // Arctangent of 2^-i in units of 2^-32 turn.
    function automatic logic [29:0] atan_turn(input logic [4:0] idx);
        logic [29:0] v;
        case (idx)
            5'd0:  v = 30'd536870912;
            5'd1:  v = 30'd316933406;
            5'd2:  v = 30'd167458907;
            5'd3:  v = 30'd85004756;
            5'd4:  v = 30'd42667331;
            5'd5:  v = 30'd21354465;
            5'd6:  v = 30'd10679838;
            5'd7:  v = 30'd5340245;
            5'd8:  v = 30'd2670163;
            5'd9:  v = 30'd1335087;
            5'd10: v = 30'd667544;
            5'd11: v = 30'd333772;
            5'd12: v = 30'd166886;
            5'd13: v = 30'd83443;
            5'd14: v = 30'd41722;
            5'd15: v = 30'd20861;
            5'd16: v = 30'd10430;
            5'd17: v = 30'd5215;
            5'd18: v = 30'd2608;
            5'd19: v = 30'd1304;
            5'd20: v = 30'd652;
            5'd21: v = 30'd326;
            5'd22: v = 30'd163;
            5'd23: v = 30'd81;
            5'd24: v = 30'd41;
            5'd25: v = 30'd20;
            5'd26: v = 30'd10;
            5'd27: v = 30'd5;
            5'd28: v = 30'd3;
            5'd29: v = 30'd1;
            5'd30: v = 30'd1;
            default: v = 30'd0;
        endcase
        return v;
    endfunction

endpackage

@@ rtl/apg_phase_div.sv @@
`timescale 1ns / 1ps
// Pipelined restoring divider that turns the scaled arc product into a phase word.
// One quotient bit per stage; depends on apg_pkg.
module apg_phase_div #(
    parameter int DEN_W = 19
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_en,
    input  logic                        i_vld,
    input  apg_pkg::t_side              i_side,
    input  logic [DEN_W:0]              i_rem,
    input  logic [apg_pkg::Q_BITS-1:0]  i_nlo,
    input  logic [DEN_W-1:0]            i_den,
    output logic                        o_vld,
    output apg_pkg::t_side              o_side,
    output logic [apg_pkg::PHASE_W-1:0] o_phase
);
    import apg_pkg::*;

    localparam int REM_W = DEN_W + 1;
    localparam int NS    = Q_BITS;

    logic               r_vld  [NS];
    t_side              r_side [NS];
    logic [REM_W-1:0]   r_rem  [NS];
    logic [Q_BITS-1:0]  r_nlo  [NS];
    logic [PHASE_W-1:0] r_q    [NS];
    logic [DEN_W-1:0]   r_den  [NS];

    for (genvar k = 0; k < NS; k++) begin : g_stage
        logic               p_vld;
        t_side              p_side;
        logic [REM_W-1:0]   p_rem;
        logic [Q_BITS-1:0]  p_nlo;
        logic [PHASE_W-1:0] p_q;
        logic [DEN_W-1:0]   p_den;
        logic [REM_W-1:0]   trial;
        logic               ge;
        logic [REM_W-1:0]   n_rem;

        if (k == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_side = i_side;
            assign p_rem  = i_rem;
            assign p_nlo  = i_nlo;
            assign p_q    = '0;
            assign p_den  = i_den;
        end else begin : g_next
            assign p_vld  = r_vld[k-1];
            assign p_side = r_side[k-1];
            assign p_rem  = r_rem[k-1];
            assign p_nlo  = r_nlo[k-1];
            assign p_q    = r_q[k-1];
            assign p_den  = r_den[k-1];
        end

        assign trial = {p_rem[REM_W-2:0], p_nlo[Q_BITS-1]};
        assign ge    = trial >= {1'b0, p_den};
        assign n_rem = ge ? (trial - {1'b0, p_den}) : trial;

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[k] <= 1'b0;
            end else if (i_en) begin
                r_vld[k] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[k] <= p_side;
                r_rem[k]  <= n_rem;
                r_nlo[k]  <= {p_nlo[Q_BITS-2:0], 1'b0};
                r_q[k]    <= {p_q[PHASE_W-2:0], ge};
                r_den[k]  <= p_den;
            end
        end
    end

    assign o_vld   = r_vld[NS-1];
    assign o_side  = r_side[NS-1];
    assign o_phase = r_q[NS-1];

endmodule

@@ rtl/apg_cordic.sv @@
`timescale 1ns / 1ps
// Pipelined CORDIC rotator, one micro-rotation per register stage.
// Depends on apg_pkg for the arctangent table and the sideband type.
module apg_cordic #(
    parameter int STAGES = 20,
    parameter int XW     = 40
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_en,
    input  logic                  i_vld,
    input  apg_pkg::t_side        i_side,
    input  logic [1:0]            i_quad,
    input  logic [29:0]           i_angle,
    input  logic signed [XW-1:0]  i_x0,
    output logic                  o_vld,
    output apg_pkg::t_side        o_side,
    output logic [1:0]            o_quad,
    output logic signed [XW-1:0]  o_x,
    output logic signed [XW-1:0]  o_y
);
    import apg_pkg::*;

    localparam int ZW = 34;

    logic                 r_vld  [STAGES];
    t_side                r_side [STAGES];
    logic [1:0]           r_quad [STAGES];
    logic signed [XW-1:0] r_x    [STAGES];
    logic signed [XW-1:0] r_y    [STAGES];
    logic signed [ZW-1:0] r_z    [STAGES];

    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        logic                 p_vld;
        t_side                p_side;
        logic [1:0]           p_quad;
        logic signed [XW-1:0] p_x;
        logic signed [XW-1:0] p_y;
        logic signed [ZW-1:0] p_z;
        logic signed [XW-1:0] dx;
        logic signed [XW-1:0] dy;
        logic signed [ZW-1:0] da;

        if (i == 0) begin : g_first
            assign p_vld  = i_vld;
            assign p_side = i_side;
            assign p_quad = i_quad;
            assign p_x    = i_x0;
            assign p_y    = '0;
            assign p_z    = signed'({{(ZW-30){1'b0}}, i_angle});
        end else begin : g_next
            assign p_vld  = r_vld[i-1];
            assign p_side = r_side[i-1];
            assign p_quad = r_quad[i-1];
            assign p_x    = r_x[i-1];
            assign p_y    = r_y[i-1];
            assign p_z    = r_z[i-1];
        end

        assign dx = p_y >>> i;
        assign dy = p_x >>> i;
        assign da = signed'({{(ZW-30){1'b0}}, atan_turn(5'(i))});

        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_vld[i] <= 1'b0;
            end else if (i_en) begin
                r_vld[i] <= p_vld;
            end
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_side[i] <= p_side;
                r_quad[i] <= p_quad;
                if (!p_z[ZW-1]) begin
                    r_x[i] <= p_x - dx;
                    r_y[i] <= p_y + dy;
                    r_z[i] <= p_z - da;
                end else begin
                    r_x[i] <= p_x + dx;
                    r_y[i] <= p_y - dy;
                    r_z[i] <= p_z + da;
                end
            end
        end
    end

    assign o_vld  = r_vld[STAGES-1];
    assign o_side = r_side[STAGES-1];
    assign o_quad = r_quad[STAGES-1];
    assign o_x    = r_x[STAGES-1];
    assign o_y    = r_y[STAGES-1];

endmodule

@@ rtl/arc_point_generator.sv @@
`timescale 1ns / 1ps
// Arc point generator: its pipeline is made of the 33 one-bit stages of the phase divider,
// the ANGLE_STAGES CORDIC stages, and set-up, rounding and output stages.
// Throughput is one point per cycle; the whole pipeline holds while the output beat waits.
// Reset (synchronous, active low) empties the pipeline and loads radius 256, 32 segments
// and a closed 360 degree ring. Depends on apg_pkg, apg_phase_div and apg_cordic.
module arc_point_generator #(
    parameter int MAX_SEGMENTS = 512,
    parameter int ANGLE_STAGES = 20
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Configuration write port.
    input  logic                 i_cfg_we,
    input  logic [1:0]           i_cfg_idx,
    input  logic [16:0]          i_cfg_data,
    // Input channel.
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [9:0]           i_point_index,
    // Output channel.
    output logic                 o_valid,
    input  logic                 i_ready,
    output logic signed [21:0]   o_pos_x,
    output logic signed [21:0]   o_pos_z,
    output logic                 o_point_valid,
    output logic                 o_last_point,
    output logic                 o_curve_closed
);
    import apg_pkg::*;

    // Widths that follow from the segment limit. The divisor is segments*360, the phase
    // numerator and divisor both having been reduced by a common factor of 256.
    localparam int SEG_W = $clog2(MAX_SEGMENTS + 1);
    localparam int DEN_W = SEG_W + 9;
    localparam int REM_W = DEN_W + 1;
    localparam int XW    = 40;
    localparam int CW    = XW - 16;

    // Configuration registers.
    logic [12:0] r_radius;
    logic [9:0]  r_seg;
    logic [16:0] r_arc;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_radius <= 13'd256;
            r_seg    <= 10'd32;
            r_arc    <= 17'(FULL_ARC);
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_RADIUS: r_radius <= i_cfg_data[12:0];
                CFG_SEG:    r_seg    <= i_cfg_data[9:0];
                CFG_ARC:    r_arc    <= i_cfg_data;
                default:    ;
            endcase
        end
    end

    // The pipeline moves as one whenever the output register is free or being emptied.
    logic en;
    assign en      = !o_valid || i_ready;
    assign o_ready = en;

    // The CORDIC start vector depends on the radius only. The user must change the configuration
    // only while the block is empty (the block does not enforce this); the vector is recomputed every cycle.
    logic [44:0]          rad_prod;
    logic signed [XW-1:0] r_x0;
    assign rad_prod = 45'(r_radius) * 45'(GAIN_Q32);

    always_ff @(posedge i_clk) begin
        r_x0 <= signed'({{(XW-37){1'b0}}, rad_prod[44:8]});
    end

    // Set-up stage: saturate the registers, work out the point count and flags, and form
    // the dividend and divisor of the phase.
    logic [SEG_W-1:0]  seg_sat;
    logic [16:0]       arc_sat;
    logic              closed;
    logic [SEG_W:0]    count;
    logic              idx_ok;
    logic              idx_last;
    logic [PROD_W-1:0] arc_prod;
    logic [23:0]       half_den;
    logic [DEN_W-1:0]  den;
    logic [REM_W+17:0] rem_ext;

    always_comb begin
        if (32'(r_seg) < MIN_SEG) begin
            seg_sat = SEG_W'(MIN_SEG);
        end else if (32'(r_seg) > MAX_SEGMENTS) begin
            seg_sat = SEG_W'(MAX_SEGMENTS);
        end else begin
            seg_sat = SEG_W'(r_seg);
        end
        arc_sat  = (32'(r_arc) > FULL_ARC) ? 17'(FULL_ARC) : r_arc;
        closed   = (32'(arc_sat) == FULL_ARC);
        count    = closed ? {1'b0, seg_sat} : ({1'b0, seg_sat} + 1'b1);
        idx_ok   = 32'(i_point_index) < 32'(count);
        idx_last = idx_ok && (32'(i_point_index) == (32'(count) - 32'd1));
        arc_prod = PROD_W'(arc_sat) * PROD_W'(i_point_index);
        half_den = 24'(32'(seg_sat) * 32'd180);
        den      = DEN_W'(32'(seg_sat) * 32'd360);
        rem_ext  = {{REM_W{1'b0}}, arc_prod[PROD_W-1:9]};
    end

    logic              r_s0_vld;
    t_side             r_s0_side;
    logic [REM_W-1:0]  r_s0_rem;
    logic [Q_BITS-1:0] r_s0_nlo;
    logic [DEN_W-1:0]  r_s0_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s0_vld <= 1'b0;
        end else if (en) begin
            r_s0_vld <= i_valid;
        end
    end

    // The dividend is arc*index*2^24 plus half the divisor; the low 24 bits are just the
    // half divisor, so it is a concatenation. Its top bits seed the partial remainder.
    always_ff @(posedge i_clk) begin
        if (en) begin
            r_s0_side <= '{point_valid: idx_ok, last_point: idx_last, curve_closed: closed};
            r_s0_rem  <= rem_ext[REM_W-1:0];
            r_s0_nlo  <= {arc_prod[8:0], half_den};
            r_s0_den  <= den;
        end
    end

    // Phase in units of 2^-32 turn.
    logic               div_vld;
    t_side              div_side;
    logic [PHASE_W-1:0] div_phase;

    apg_phase_div #(
        .DEN_W (DEN_W)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (r_s0_vld),
        .i_side  (r_s0_side),
        .i_rem   (r_s0_rem),
        .i_nlo   (r_s0_nlo),
        .i_den   (r_s0_den),
        .o_vld   (div_vld),
        .o_side  (div_side),
        .o_phase (div_phase)
    );

    // The top two phase bits pick the quadrant; the rest is rotated.
    logic                 cor_vld;
    t_side                cor_side;
    logic [1:0]           cor_quad;
    logic signed [XW-1:0] cor_x;
    logic signed [XW-1:0] cor_y;

    apg_cordic #(
        .STAGES (ANGLE_STAGES),
        .XW     (XW)
    ) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (en),
        .i_vld   (div_vld),
        .i_side  (div_side),
        .i_quad  (div_phase[31:30]),
        .i_angle (div_phase[29:0]),
        .i_x0    (r_x0),
        .o_vld   (cor_vld),
        .o_side  (cor_side),
        .o_quad  (cor_quad),
        .o_x     (cor_x),
        .o_y     (cor_y)
    );

    // Rounding stage: drop the 16 guard bits, rounding half up.
    localparam logic signed [XW-1:0] HALF = XW'(32768);
    logic signed [XW-1:0] x_rnd;
    logic signed [XW-1:0] y_rnd;
    logic                 r_rnd_vld;
    t_side                r_rnd_side;
    logic [1:0]           r_rnd_quad;
    logic signed [CW-1:0] r_cos;
    logic signed [CW-1:0] r_sin;

    assign x_rnd = (cor_x + HALF) >>> 16;
    assign y_rnd = (cor_y + HALF) >>> 16;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rnd_vld <= 1'b0;
        end else if (en) begin
            r_rnd_vld <= cor_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rnd_side <= cor_side;
            r_rnd_quad <= cor_quad;
            r_cos      <= x_rnd[CW-1:0];
            r_sin      <= y_rnd[CW-1:0];
        end
    end

    // Output stage: map the quadrant, saturate to 22 bits, and force an invalid point
    // to the origin.
    localparam logic signed [CW:0] OUT_HI = (CW+1)'(2097151);
    localparam logic signed [CW:0] OUT_LO = -(CW+1)'(2097152);
    logic signed [CW:0] c_ext;
    logic signed [CW:0] s_ext;
    logic signed [CW:0] px;
    logic signed [CW:0] pz;
    logic signed [OUT_W-1:0] n_pos_x;
    logic signed [OUT_W-1:0] n_pos_z;

    always_comb begin
        c_ext = {r_cos[CW-1], r_cos};
        s_ext = {r_sin[CW-1], r_sin};
        case (r_rnd_quad)
            2'd0:    begin px = c_ext;  pz = s_ext;  end
            2'd1:    begin px = -s_ext; pz = c_ext;  end
            2'd2:    begin px = -c_ext; pz = -s_ext; end
            default: begin px = s_ext;  pz = -c_ext; end
        endcase
        if (px > OUT_HI) begin
            n_pos_x = OUT_HI[OUT_W-1:0];
        end else if (px < OUT_LO) begin
            n_pos_x = OUT_LO[OUT_W-1:0];
        end else begin
            n_pos_x = px[OUT_W-1:0];
        end
        if (pz > OUT_HI) begin
            n_pos_z = OUT_HI[OUT_W-1:0];
        end else if (pz < OUT_LO) begin
            n_pos_z = OUT_LO[OUT_W-1:0];
        end else begin
            n_pos_z = pz[OUT_W-1:0];
        end
        if (!r_rnd_side.point_valid) begin
            n_pos_x = '0;
            n_pos_z = '0;
        end
    end

    logic r_o_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_o_valid <= 1'b0;
        end else if (en) begin
            r_o_valid <= r_rnd_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            o_pos_x        <= n_pos_x;
            o_pos_z        <= n_pos_z;
            o_point_valid  <= r_rnd_side.point_valid;
            o_last_point   <= r_rnd_side.last_point;
            o_curve_closed <= r_rnd_side.curve_closed;
        end
    end

    assign o_valid = r_o_valid;

    // An index outside the curve always comes out at the origin.
    a_invalid_origin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_point_valid |-> (o_pos_x == '0) && (o_pos_z == '0))
        else $error("invalid point not at origin");

    // Only a point on the curve can be its final point.
    a_last_on_curve: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_last_point |-> o_point_valid)
        else $error("last point flagged on invalid index");

    // A beat appears at the output only when the rounding stage held an item.
    a_out_from_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_valid) |-> $past(r_rnd_vld))
        else $error("output beat without a pipeline item");

endmodule
